### sv/efcp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the escaped frame parser.
// No dependencies; every other file of the block imports this package.
package efcp_pkg;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA6BC;

    localparam logic [7:0] START_RESET  = 8'hC0;
    localparam logic [7:0] ESCAPE_RESET = 8'hCA;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_ID      = 4'd1,
        ST_SUBID   = 4'd2,
        ST_LENGTH  = 4'd3,
        ST_PAYLOAD = 4'd4,
        ST_CRC1    = 4'd5,
        ST_CRC2    = 4'd6,
        ST_SUCCESS = 4'd7,
        ST_FAILURE = 4'd8
    } t_state;

    typedef enum logic [2:0] {
        KIND_ID       = 3'd0,
        KIND_SUBID    = 3'd1,
        KIND_LENGTH   = 3'd2,
        KIND_PAYLOAD  = 3'd3,
        KIND_CRC_HIGH = 3'd4,
        KIND_CRC_LOW  = 3'd5
    } t_kind;

    typedef enum logic [0:0] {
        REG_START  = 1'b0,
        REG_ESCAPE = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] escape_byte;
    } t_cfg;

    typedef struct packed {
        logic [15:0] computed_crc;
        logic [7:0]  payload_index;
        logic [7:0]  field_byte;
        t_kind       field_kind;
        logic        field_valid;
        t_state      parse_status;
    } t_result;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/escaped_frame_crc_parser_core.sv
// Top level of the escaped frame parser: configuration port, parser and result register.
// Depends on efcp_pkg, efcp_apb_regs and efcp_parser.
//
// The core takes one stuffed byte per transaction and returns exactly one result
// transaction per byte, sustaining one byte per clock cycle while the output is not
// stalled. A byte passes through the input register, is decoded and folded into
// the CRC-16 (reflected polynomial 0x3D65) in the same cycle that the parser state
// advances, and lands in the result register, from which the result is presented.
// A result is taken from the result register when the output is not stalled.
// The rate is set by the parser state register, which is updated once per byte.
// Start and escape byte values are written over the APB port at addresses 0x0 and
// 0x4 and should be changed only while no transaction is in flight.
module escaped_frame_crc_parser_core
    import efcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: raw_byte[7:0].
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: parse_status[3:0], field_byte[11:4], payload_index[19:12],
    // computed_crc[35:20], zero fill[39:36].
    output logic [39:0]           m_axis_tdata,
    // Fields from bit 0: field_valid[0], field_kind[3:1].
    output logic [3:0]            m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_result w_res;
    t_result r_res;
    logic    w_res_valid;
    logic    w_res_ready;
    logic    r_out_valid;

    efcp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    efcp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = ~r_out_valid | m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_res.computed_crc, r_res.payload_index,
                            r_res.field_byte, r_res.parse_status};
    assign m_axis_tuser  = {r_res.field_kind, r_res.field_valid};

endmodule

### sv/efcp_apb_regs.sv
// APB-style configuration registers holding the start and escape byte values.
// Depends on efcp_pkg for the register index codes and reset values.
module efcp_apb_regs
    import efcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [7:0] r_start;
    logic [7:0] r_escape;
    logic       w_write;
    t_reg_index w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (w_write) begin
            unique case (w_index)
                REG_START:  r_start  <= pwdata[7:0];
                REG_ESCAPE: r_escape <= pwdata[7:0];
                default:    r_start  <= r_start;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_START:  prdata = {{(APB_DATA_W-8){1'b0}}, r_start};
            REG_ESCAPE: prdata = {{(APB_DATA_W-8){1'b0}}, r_escape};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = {r_start, r_escape};

endmodule

### sv/efcp_parser.sv
// Input byte register, frame parser state and the combinational decode and CRC step.
// Depends on efcp_pkg for the state and kind enums, the result struct and crc_fold.
module efcp_parser
    import efcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_state      r_state;
    t_state      n_state;
    logic        r_esc;
    logic        n_esc;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic [7:0]  r_crc_high;
    logic [7:0]  n_crc_high;
    logic        w_fire;
    logic        w_decoded;
    logic [7:0]  w_byte;
    logic [7:0]  w_count_inc;

    assign w_fire      = r_in_valid & i_res_ready;
    assign o_in_ready  = ~r_in_valid | i_res_ready;
    assign o_res_valid = r_in_valid;
    assign w_count_inc = r_count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_esc      <= 1'b0;
            r_crc      <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_crc_high <= '0;
        end else if (w_fire) begin
            r_state    <= n_state;
            r_esc      <= n_esc;
            r_crc      <= n_crc;
            r_len      <= n_len;
            r_count    <= n_count;
            r_crc_high <= n_crc_high;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_esc      = r_esc;
        n_crc      = r_crc;
        n_len      = r_len;
        n_count    = r_count;
        n_crc_high = r_crc_high;
        w_decoded  = 1'b1;
        w_byte     = r_in_byte;

        o_res.field_valid   = 1'b0;
        o_res.field_kind    = KIND_ID;
        o_res.field_byte    = '0;
        o_res.payload_index = '0;

        if (r_in_byte == i_cfg.start_byte) begin
            n_crc     = crc_fold(CRC_SEED, r_in_byte);
            n_state   = ST_ID;
            w_decoded = 1'b0;
        end else begin
            if (r_state == ST_ID || r_state == ST_SUBID || r_state == ST_LENGTH
                    || r_state == ST_PAYLOAD) begin
                n_crc = crc_fold(r_crc, r_in_byte);
            end
            if (r_esc) begin
                n_esc = 1'b0;
                if (r_in_byte == 8'h00
                        || r_in_byte == (i_cfg.start_byte ^ i_cfg.escape_byte)) begin
                    w_byte = r_in_byte ^ i_cfg.escape_byte;
                end else begin
                    n_state   = ST_HUNT;
                    w_decoded = 1'b0;
                end
            end else if (r_in_byte == i_cfg.escape_byte) begin
                n_esc     = 1'b1;
                w_decoded = 1'b0;
            end
        end

        if (w_decoded) begin
            o_res.field_valid = 1'b1;
            o_res.field_byte  = w_byte;
            unique case (r_state)
                ST_ID: begin
                    o_res.field_kind = KIND_ID;
                    n_state          = ST_SUBID;
                end
                ST_SUBID: begin
                    o_res.field_kind = KIND_SUBID;
                    n_state          = ST_LENGTH;
                end
                ST_LENGTH: begin
                    o_res.field_kind = KIND_LENGTH;
                    n_count          = '0;
                    n_len            = w_byte;
                    n_state          = (w_byte == 8'h00) ? ST_CRC1 : ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    o_res.field_kind    = KIND_PAYLOAD;
                    o_res.payload_index = r_count;
                    n_count             = w_count_inc;
                    if (w_count_inc == r_len) begin
                        n_state = ST_CRC1;
                    end
                end
                ST_CRC1: begin
                    o_res.field_kind = KIND_CRC_HIGH;
                    n_crc_high       = w_byte;
                    n_state          = ST_CRC2;
                end
                ST_CRC2: begin
                    o_res.field_kind = KIND_CRC_LOW;
                    n_crc            = r_crc ^ CRC_SEED;
                    n_state          = ((r_crc ^ CRC_SEED) == {r_crc_high, w_byte})
                                       ? ST_SUCCESS : ST_FAILURE;
                end
                default: begin
                    o_res.field_valid = 1'b0;
                    o_res.field_byte  = '0;
                    n_state           = ST_HUNT;
                end
            endcase
        end

        o_res.parse_status = n_state;
        o_res.computed_crc = n_crc;
    end

endmodule
